// ===== design/lzssw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzssw_pkg: shared types and constants of the LZSS window decompressor
// Window geometry, token field widths, reset values and the result item type.
// ----------------------------------------------------------------------------
package lzssw_pkg;

  // Window geometry. Match positions are 12-bit absolute, so this is fixed.
  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = WIN_AW + 1;

  // Token and counter widths.
  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 24;
  localparam int LEN_W   = 5;
  localparam int FLAG_W  = 9;

  // Reset values and token constants.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;
  localparam logic [WIN_AW-1:0]  WPOS_RESET  = 12'd1;
  localparam logic [LEN_W-1:0]   MIN_MATCH   = 5'd2;
  localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(WINDOW_SIZE);

  // Output buffer geometry.
  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_CW    = 2;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_item_t;

endpackage

// ===== design/lzssw_ifs.sv =====
// ----------------------------------------------------------------------------
// lzssw_ifs: valid/ready channels of the LZSS window decompressor
// Input channel carries compressed bytes, output channel decompressed bytes.
// ----------------------------------------------------------------------------
interface lzssw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzssw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== design/lzssw_ram.sv =====
// ----------------------------------------------------------------------------
// lzssw_ram: generic simple dual-port RAM
// One write port, one read port with registered data; a read of the address
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module lzssw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lzssw_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lzssw_out_fifo: two-entry output buffer
// Holds finished result items so the window engine keeps running while the
// consumer stalls; the output side is driven straight from flip-flops.
// ----------------------------------------------------------------------------
module lzssw_out_fifo
  import lzssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  out_item_t          push_item,
  input  logic               pop,
  output logic               valid,
  output out_item_t          head,
  output logic [OBUF_CW-1:0] count
);

  out_item_t          ent_r [OBUF_DEPTH];
  logic               wptr_r, wptr_nxt;
  logic               rptr_r, rptr_nxt;
  logic [OBUF_CW-1:0] cnt_r, cnt_nxt;

  // Pointer and count update.
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + OBUF_CW'(push) - OBUF_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_item;
    end
  end

  assign valid = (cnt_r != '0);
  assign head  = ent_r[rptr_r];
  assign count = cnt_r;

  // A push never lands on a full buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (cnt_r != OBUF_CW'(OBUF_DEPTH)))
    else $error("output buffer overflow");

  // The count goes up by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + OBUF_CW'(1)))
    else $error("output buffer count lost a push");

endmodule

// ===== design/lzssw_window_engine_note.sv =====
// ----------------------------------------------------------------------------
// lzssw_fill_check: window entry validity from the fill count
// An entry reads as zero until written in the current stream. Writes run
// sequentially from the reset write position, so an entry is valid when its
// distance from that start is below the saturating fill count.
// ----------------------------------------------------------------------------
module lzssw_fill_check
  import lzssw_pkg::*;
(
  input  logic [WIN_AW-1:0] pos,
  input  logic [FILL_W-1:0] fill,
  output logic              unwritten
);

  logic [WIN_AW-1:0] offset;

  // Distance of the entry from the first write position, modulo the window.
  assign offset    = pos - WPOS_RESET;
  assign unwritten = ({1'b0, offset} >= fill);

endmodule

// ===== design/lzss_window_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_window_decompressor: LZSS decoder with a 4 KiB absolute window
// Decodes flag, literal and match tokens one compressed byte per item and
// copies match bytes out of a window memory.
//
//   Channel   Dir  Handshake        Payload
//   in_ch     in   valid / ready    in_byte[7:0], new_stream
//   out_ch    out  valid / ready    out_byte[7:0], last_of_run
//   cfg_*     in   cfg_we           cfg_wdata[23:0] (out_limit)
//
// A match-low byte is first decoded, then the copy issues one window read
// per output byte on the single read port, and the next item waits until the
// last read has returned.
// Reset needs no clearing pass: a fill count marks unwritten window entries,
// which read as zero. A two-entry output buffer absorbs consumer stalls; the
// window reads pause while it has no room.
// ----------------------------------------------------------------------------
module lzss_window_decompressor
  import lzssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  lzssw_in_if.sink           in_ch,
  lzssw_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  // Stream state.
  logic [FLAG_W-1:0]  flag_r, flag_nxt;
  logic               phase_r, phase_nxt;
  logic [BYTE_W-1:0]  mh_r, mh_nxt;
  logic [LIMIT_W-1:0] bo_r, bo_nxt;
  logic [WIN_AW-1:0]  wp_r, wp_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  // Copy engine state.
  logic               cp_act_r, cp_act_nxt;
  logic [WIN_AW-1:0]  cp_pos_r, cp_pos_nxt;
  logic [LEN_W-1:0]   cp_len_r, cp_len_nxt;

  // Read in flight.
  logic               rd_pend_r;
  logic               rd_last_r;
  logic               rd_fwd_r;
  logic               rd_zero_r;
  logic [BYTE_W-1:0]  rd_fwd_data_r;

  // Stream state as seen by the item, after an optional restart.
  logic [FLAG_W-1:0]  flag_b;
  logic               phase_b;
  logic [BYTE_W-1:0]  mh_b;
  logic [LIMIT_W-1:0] bo_b;
  logic [WIN_AW-1:0]  wp_b;
  logic [FILL_W-1:0]  fill_b;

  logic               in_fire;
  logic               ignore;
  logic               lit_fire;
  logic               pop;
  logic [OBUF_CW-1:0] obuf_cnt;
  logic [OBUF_CW-1:0] occ_eff;
  logic               issue;
  logic               issue_last;
  logic               unwritten;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [BYTE_W-1:0]  arr_byte;
  logic               wr_en;
  logic [BYTE_W-1:0]  wr_data;
  out_item_t          push_item;
  out_item_t          head;

  // Input handshake: one item at a time, with room for a literal.
  assign in_ch.ready = !cp_act_r && !rd_pend_r && (obuf_cnt != OBUF_CW'(OBUF_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // A new stream starts from reset values before its first byte is decoded.
  always_comb begin
    if (in_fire && in_ch.new_stream) begin
      flag_b  = '0;
      phase_b = 1'b0;
      mh_b    = '0;
      bo_b    = '0;
      wp_b    = WPOS_RESET;
      fill_b  = '0;
    end else begin
      flag_b  = flag_r;
      phase_b = phase_r;
      mh_b    = mh_r;
      bo_b    = bo_r;
      wp_b    = wp_r;
      fill_b  = fill_r;
    end
  end

  // Token decode.
  assign ignore   = (bo_b >= limit_r);
  assign lit_fire = in_fire && !ignore && !phase_b && (flag_b[FLAG_W-1:1] != '0) && flag_b[0];

  // Window reads: one per cycle while the output buffer has a free slot.
  assign pop        = out_ch.valid && out_ch.ready;
  assign occ_eff    = obuf_cnt - OBUF_CW'(pop);
  assign issue      = cp_act_r && ((occ_eff + OBUF_CW'(rd_pend_r)) < OBUF_CW'(OBUF_DEPTH));
  assign issue_last = (cp_len_r == LEN_W'(1)) || ((bo_r + LIMIT_W'(1)) == limit_r);

  lzssw_fill_check u_fill_check (
    .pos       (cp_pos_r),
    .fill      (fill_r),
    .unwritten (unwritten)
  );

  // Returning byte: forwarded write, unwritten entry, or memory data.
  always_comb begin
    if (rd_fwd_r) begin
      arr_byte = rd_fwd_data_r;
    end else if (rd_zero_r) begin
      arr_byte = '0;
    end else begin
      arr_byte = ram_rdata;
    end
  end

  // Every output byte is written back into the window.
  assign wr_en   = lit_fire || rd_pend_r;
  assign wr_data = rd_pend_r ? arr_byte : in_ch.in_byte;

  lzssw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp_b),
    .wdata (wr_data),
    .re    (issue),
    .raddr (cp_pos_r),
    .rdata (ram_rdata)
  );

  // Next-state logic for stream and copy state.
  always_comb begin
    flag_nxt   = flag_r;
    phase_nxt  = phase_r;
    mh_nxt     = mh_r;
    bo_nxt     = bo_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    cp_act_nxt = cp_act_r;
    cp_pos_nxt = cp_pos_r;
    cp_len_nxt = cp_len_r;
    limit_nxt  = cfg_we ? cfg_wdata : limit_r;

    if (in_fire) begin
      flag_nxt  = flag_b;
      phase_nxt = phase_b;
      mh_nxt    = mh_b;
      bo_nxt    = bo_b;
      wp_nxt    = wp_b;
      fill_nxt  = fill_b;
      if (!ignore) begin
        priority if (phase_b) begin
          // Match-low byte: start the copy.
          cp_act_nxt = 1'b1;
          cp_pos_nxt = {mh_b, in_ch.in_byte[7:4]};
          cp_len_nxt = {1'b0, in_ch.in_byte[3:0]} + MIN_MATCH;
          flag_nxt   = flag_b >> 1;
          phase_nxt  = 1'b0;
        end else if (flag_b[FLAG_W-1:1] == '0) begin
          // Flag byte under a marker bit.
          flag_nxt = {1'b1, in_ch.in_byte};
        end else if (flag_b[0]) begin
          // Literal.
          flag_nxt = flag_b >> 1;
          bo_nxt   = bo_b + LIMIT_W'(1);
        end else begin
          // Match-high byte.
          mh_nxt    = in_ch.in_byte;
          phase_nxt = 1'b1;
        end
      end
    end

    // Copy step on each window read.
    if (issue) begin
      cp_pos_nxt = cp_pos_r + WIN_AW'(1);
      cp_len_nxt = cp_len_r - LEN_W'(1);
      bo_nxt     = bo_r + LIMIT_W'(1);
      if (issue_last) begin
        cp_act_nxt = 1'b0;
      end
    end

    // Window write advances the position and the fill count.
    if (wr_en) begin
      wp_nxt   = wp_b + WIN_AW'(1);
      fill_nxt = (fill_b == FILL_FULL) ? fill_b : fill_b + FILL_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= '0;
      phase_r   <= 1'b0;
      mh_r      <= '0;
      bo_r      <= '0;
      wp_r      <= WPOS_RESET;
      fill_r    <= '0;
      limit_r   <= LIMIT_RESET;
      cp_act_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      flag_r    <= flag_nxt;
      phase_r   <= phase_nxt;
      mh_r      <= mh_nxt;
      bo_r      <= bo_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      limit_r   <= limit_nxt;
      cp_act_r  <= cp_act_nxt;
      rd_pend_r <= issue;
    end
  end

  // Copy payload and read-in-flight tags; a read of the entry written in the
  // same cycle takes the written byte.
  always_ff @(posedge clk) begin
    cp_pos_r <= cp_pos_nxt;
    cp_len_r <= cp_len_nxt;
    if (issue) begin
      rd_last_r     <= issue_last;
      rd_fwd_r      <= rd_pend_r && (cp_pos_r == wp_r);
      rd_fwd_data_r <= arr_byte;
      rd_zero_r     <= unwritten;
    end
  end

  // Result items enter the output buffer.
  always_comb begin
    if (rd_pend_r) begin
      push_item.out_byte    = arr_byte;
      push_item.last_of_run = rd_last_r;
    end else begin
      push_item.out_byte    = in_ch.in_byte;
      push_item.last_of_run = 1'b1;
    end
  end

  lzssw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wr_en),
    .push_item (push_item),
    .pop       (pop),
    .valid     (out_ch.valid),
    .head      (head),
    .count     (obuf_cnt)
  );

  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.last_of_run = head.last_of_run;

  // A returning read always finds room in the output buffer.
  a_room_for_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (obuf_cnt != OBUF_CW'(OBUF_DEPTH)))
    else $error("window read returned into a full output buffer");

  // An active copy always has bytes left.
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    cp_act_r |-> (cp_len_r != '0))
    else $error("copy active with zero length");

  // The fill count saturates at the window size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window size");

  // Each window read is followed by exactly one window write.
  a_read_writes: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (wr_en && !lit_fire))
    else $error("window read without write-back");

endmodule

// ===== tb/sv/lzssw_stream_checker.sv =====
// ----------------------------------------------------------------------------
// lzssw_stream_checker: prediction and comparison for the LZSS decompressor
// Watches the input and result channels and the limit register writes. It
// keeps its own copy of the window and the token decoder, and turns each
// accepted input item into the decompressed bytes it should release. Those
// bytes are compared in order with the result items.
// ----------------------------------------------------------------------------
module lzssw_stream_checker
  import lzssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  lzssw_in_if                in_ch,
  lzssw_out_if               out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);

  // The decoder only ever waits for a token start or for a match-low byte.
  typedef enum logic [1:0] {
    TOKEN_START = 2'd0,
    MATCH_LOW   = 2'd1
  } token_phase_t;

  logic [BYTE_W-1:0]  win_mem [WINDOW_SIZE];
  logic [WIN_AW-1:0]  wr_pos;
  logic [FLAG_W-1:0]  flag_sr;
  token_phase_t       phase;
  logic [BYTE_W-1:0]  hi_byte;
  logic [LIMIT_W-1:0] produced;
  logic [LIMIT_W-1:0] byte_limit;
  out_item_t          expected_bytes [$];
  out_item_t          got_item;
  out_item_t          want_item;
  int                 n_fail = 0;

  // Start of a stream: empty window, first write at position one.
  task automatic clear_stream();
    foreach (win_mem[i]) win_mem[i] = '0;
    wr_pos   = WPOS_RESET;
    flag_sr  = '0;
    phase    = TOKEN_START;
    hi_byte  = '0;
    produced = '0;
  endtask

  // Every decompressed byte also lands in the window.
  task automatic put_byte(input logic [BYTE_W-1:0] value);
    out_item_t entry;
    entry.out_byte    = value;
    entry.last_of_run = 1'b0;
    win_mem[wr_pos]   = value;
    wr_pos            = wr_pos + WIN_AW'(1);
    produced          = produced + LIMIT_W'(1);
    expected_bytes.insert(expected_bytes.size(), entry);
  endtask

  // Decode one compressed byte and queue the bytes it completes.
  task automatic decode_item(input logic [BYTE_W-1:0] b, input logic ns);
    int                first_idx;
    int                len;
    logic [WIN_AW-1:0] rd;
    out_item_t         tail;
    if (ns) clear_stream();
    if (produced >= byte_limit) return;
    first_idx = expected_bytes.size();
    if (phase == MATCH_LOW) begin
      rd  = {hi_byte, b[7:4]};
      len = int'(b[3:0]) + 2;
      // Reads see bytes written earlier in the same match when they overlap.
      while (len > 0 && produced < byte_limit) begin
        put_byte(win_mem[rd]);
        rd  = rd + WIN_AW'(1);
        len = len - 1;
      end
      flag_sr = flag_sr >> 1;
      phase   = TOKEN_START;
    end else if (flag_sr <= 1) begin
      // Flags run out: this byte is a new flag byte under a marker bit.
      flag_sr = {1'b1, b};
      phase   = TOKEN_START;
    end else if (flag_sr[0]) begin
      put_byte(b);
      flag_sr = flag_sr >> 1;
      phase   = TOKEN_START;
    end else begin
      hi_byte = b;
      phase   = MATCH_LOW;
    end
    // Mark the final byte this item released.
    if (expected_bytes.size() > first_idx) begin
      tail             = expected_bytes.pop_back();
      tail.last_of_run = 1'b1;
      expected_bytes.insert(expected_bytes.size(), tail);
    end
  endtask

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    $display("MISMATCH at %0t: %s: got byte %02h last %0b, want byte %02h last %0b",
             $realtime, what, got.out_byte, got.last_of_run, want.out_byte,
             want.last_of_run);
    n_fail++;
  endtask

  // Inputs are predicted before results are compared within one edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream();
      byte_limit = LIMIT_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_we) byte_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) decode_item(in_ch.in_byte, in_ch.new_stream);
      if (out_ch.valid && out_ch.ready) begin
        got_item = '{out_byte: out_ch.out_byte, last_of_run: out_ch.last_of_run};
        if (expected_bytes.size() == 0) begin
          report("no item expected", got_item, '0);
        end else begin
          want_item = expected_bytes.pop_front();
          if (got_item.out_byte !== want_item.out_byte)
            report("out_byte", got_item, want_item);
          if (got_item.last_of_run !== want_item.last_of_run)
            report("last_of_run", got_item, want_item);
        end
      end
    end
    fail_count    <= n_fail;
    pending_count <= expected_bytes.size();
  end

endmodule

// ===== tb/sv/lzss_window_decompressor_test.sv =====
// ----------------------------------------------------------------------------
// lzss_window_decompressor_test: top of the LZSS decompressor testbench
// Drives compressed streams into the decoder: a directed opening with edge
// tokens, then random well-formed streams mixed with truncated streams and
// noise, under several output limits and idling patterns. A checker beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_test;
  import lzssw_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  bit                 hold_req = 1'b0;
  int                 fail_count;
  int                 pending_count;
  int                 items_sent = 0;
  logic [WIN_AW-1:0]  gen_pos;

  // Opening tokens as {new_stream, byte}: literals 0x00 and 0xFF, an
  // overlapping match of full length, matches wrapping past the window end,
  // a cut match-high byte, a lone flag byte and a match from a fresh window.
  logic [8:0] opening_seq [$] = '{
    {1'b1, 8'h0D}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h1F}, {1'b0, 8'h00},
    {1'b0, 8'h80}, {1'b0, 8'hFF}, {1'b0, 8'hF0}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b0, 8'h00},
    {1'b1, 8'hFF}, {1'b0, 8'hA5}, {1'b0, 8'h01},
    {1'b1, 8'h00},
    {1'b1, 8'hAA}, {1'b0, 8'h00}, {1'b0, 8'h00}
  };

  // With a limit of five: a match cut short, an item past the limit, and a
  // new stream that starts the byte count over.
  logic [8:0] limit_seq [$] = '{
    {1'b1, 8'hFD}, {1'b0, 8'h11}, {1'b0, 8'h00}, {1'b0, 8'h1F}, {1'b0, 8'h22},
    {1'b1, 8'h01}, {1'b0, 8'h33}
  };

  lzssw_in_if  in_ch ();
  lzssw_out_if out_ch ();

  lzss_window_decompressor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lzssw_stream_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= TIMEOUT_CYCLES) begin
        $display("watchdog: no item moved for %0d cycles", TIMEOUT_CYCLES);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic ns);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.new_stream <= ns;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Wait for every expected byte, then let partial tokens settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A well-formed stream of random tokens. Matches mostly point a short way
  // back so that they copy real data and often overlap their own output.
  // With cut_last the last token is cut: a match to its high byte, no literal.
  task automatic send_stream(input int n_tokens, input bit cut_last);
    logic [7:0]        flags;
    logic [3:0]        len_code;
    logic [WIN_AW-1:0] src;
    bit                first;
    first   = 1'b1;
    gen_pos = WPOS_RESET;
    for (int t = 0; t < n_tokens; t++) begin
      if (t % 8 == 0) begin
        flags = 8'($urandom);
        send_byte(flags, first);
        first = 1'b0;
      end
      if (cut_last && t == n_tokens - 1 && flags[t % 8]) break;
      if (flags[t % 8]) begin
        send_byte(8'($urandom), 1'b0);
        gen_pos = gen_pos + WIN_AW'(1);
      end else begin
        if ($urandom_range(3) == 0)
          src = WIN_AW'($urandom);
        else
          src = gen_pos - WIN_AW'($urandom_range(1, 40));
        len_code = 4'($urandom);
        send_byte(src[11:4], 1'b0);
        if (cut_last && t == n_tokens - 1) break;
        send_byte({src[3:0], len_code}, 1'b0);
        gen_pos = gen_pos + WIN_AW'(len_code) + WIN_AW'(2);
      end
    end
  endtask

  // Mostly streams, some of them cut short, with bursts of raw noise.
  task automatic run_random(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85)
        send_stream($urandom_range(1, 24), $urandom_range(3) == 0);
      else
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.new_stream <= 1'b0;
    tx_idle_pct = 24;
    rx_idle_pct = 81;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset limit, then a limit that cuts a match.
    foreach (opening_seq[i]) send_byte(opening_seq[i][7:0], opening_seq[i][8]);
    drain();
    write_limit(24'd5);
    foreach (limit_seq[i]) send_byte(limit_seq[i][7:0], limit_seq[i][8]);
    drain();

    // A zero limit: every item is ignored.
    write_limit('0);
    send_stream(10, 1'b0);
    drain();

    // Sender idles a little, receiver a lot, no limit in reach.
    write_limit(LIMIT_RESET);
    run_random(50);
    drain();

    // Sender idles a lot, receiver a little, limits that cut streams.
    tx_idle_pct = 81;
    rx_idle_pct = 24;
    write_limit(24'd1);
    run_random(10);
    drain();
    write_limit(LIMIT_W'($urandom_range(2, 60)));
    run_random(35);
    drain();

    // No idling. A long receiver hold-off first while literals keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_limit(LIMIT_W'($urandom_range(1000, 24'hFF_FFFE)));
    hold_req <= 1'b1;
    send_byte(8'hFF, 1'b1);
    hold_req <= 1'b0;
    repeat (8) send_byte(8'($urandom), 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (8) send_byte(8'($urandom), 1'b0);
    run_random(35);
    drain();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lzssw_pkg.sv
design/lzssw_ifs.sv
design/lzssw_ram.sv
design/lzssw_out_fifo.sv
design/lzssw_window_engine_note.sv
design/lzss_window_decompressor.sv
tb/sv/lzssw_stream_checker.sv
tb/sv/lzss_window_decompressor_test.sv
